>>> rtl/grid_neighbor_expander_unit_assert.svh
// ----------------------------------------------------------------------------
// Grid neighbour expander assertion macros
// Shared assertion forms used by the modules of the grid neighbour expander.
// Each macro expects signals named clk and arst_n in the calling module.
// ----------------------------------------------------------------------------
`ifndef GRID_NEIGHBOR_EXPANDER_UNIT_ASSERT_SVH
`define GRID_NEIGHBOR_EXPANDER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GNE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GNE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gne_pkg.sv
// ----------------------------------------------------------------------------
// Grid neighbour expander package
// Field widths, codes and the candidate set handed from the query logic to
// the result emitter.
// ----------------------------------------------------------------------------
package gne_pkg;

	// Field and register widths.
	localparam int IDX_W     = 12;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	// Default geometry limits.
	localparam int MAX_SIDE_DEF  = 64;
	localparam int MAX_CELLS_DEF = 4096;

	// Reset value of both grid size registers.
	localparam logic [CFG_W-1:0] GRID_SIZE_RST = 7'd64;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Candidate slots in output order: the cell itself, then up, left, down, right.
	localparam int N_SLOT     = 5;
	localparam int SLOT_W     = 3;
	localparam int SLOT_SELF  = 0;
	localparam int SLOT_UP    = 1;
	localparam int SLOT_LEFT  = 2;
	localparam int SLOT_DOWN  = 3;
	localparam int SLOT_RIGHT = 4;

	// One finished query: which slots give a result, their indices and the
	// out-of-grid flag.
	typedef struct packed {
		logic                          bad;
		logic [N_SLOT-1:0]             mask;
		logic [N_SLOT-1:0][IDX_W-1:0]  idx;
	} gne_set_t;

endpackage

>>> rtl/gne_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module gne_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/gne_emit.sv
// ----------------------------------------------------------------------------
// Grid neighbour expander result emitter
// Holds one finished candidate set and sends its results one per cycle,
// marking the last. A new set is taken when none is pending or while the
// last result of the previous one is being sent.
// ----------------------------------------------------------------------------
`include "grid_neighbor_expander_unit_assert.svh"

module gne_emit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  gne_pkg::gne_set_t        set_in,
	output logic                     ready,
	output logic                     result_valid,
	output logic [gne_pkg::IDX_W-1:0] neighbor_index,
	output logic                     last_of_run,
	output logic                     bad_index
);

	logic [gne_pkg::N_SLOT-1:0]  mask_q;
	gne_pkg::gne_set_t           set_q;
	logic [gne_pkg::SLOT_W-1:0]  sel;
	logic                        found;
	logic [gne_pkg::N_SLOT-1:0]  rest;
	logic                        valid_q;
	logic [gne_pkg::IDX_W-1:0]   idx_q;
	logic                        last_q;
	logic                        bad_q;

	// Pick the first pending slot in output order.
	always_comb begin
		sel   = '0;
		found = 1'b0;
		for (int i = 0; i < gne_pkg::N_SLOT; i++) begin
			if (mask_q[i] && !found) begin
				sel   = gne_pkg::SLOT_W'(i);
				found = 1'b1;
			end
		end
		rest = mask_q & ~(gne_pkg::N_SLOT'(1) << sel);
	end

	// A new set may come in once at most one result of the current set remains.
	assign ready = (rest == '0);

	// Pending slots and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= |mask_q;
			mask_q  <= load ? set_in.mask : rest;
		end
	end

	// Set contents and the output register.
	always_ff @(posedge clk) begin
		if (load) begin
			set_q <= set_in;
		end
		idx_q  <= set_q.idx[sel];
		last_q <= (rest == '0);
		bad_q  <= set_q.bad;
	end

	assign result_valid   = valid_q;
	assign neighbor_index = idx_q;
	assign last_of_run    = last_q;
	assign bad_index      = bad_q;

	`GNE_ASSERT_IMP(a_load_when_ready, load, ready, "set loaded while results still pending")
	`GNE_ASSERT_IMP(a_bad_is_last, result_valid && bad_index, last_of_run,
		"out-of-grid result not marked last")
	`GNE_ASSERT_NEXT(a_run_continues, result_valid && !last_of_run, result_valid,
		"run broken off before its last result")

endmodule

>>> rtl/grid_neighbor_expander_unit.sv
// ----------------------------------------------------------------------------
// Grid neighbour expander
// Keeps a one-bit obstacle map of a configurable grid in a RAM. Write items
// set the obstacle bit of a cell; query items return the cell and, if it is
// free, its free four-connected neighbours in the order up, left, down, right.
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   -----------------------------------
//   item in   start, busy               kind, cell_index, blocked
//   config    cfg_we                    cfg_index, cfg_data
//   result    result_valid (strobe)     neighbor_index, last_of_run, bad_index
//
// A write item leaves busy low, so writes may follow each other in every
// cycle. A query item makes five map reads through the single RAM read port,
// in parallel with the one-bit-per-cycle remainder unit that finds the column.
// Results leave one per cycle from the emitter while the next item is worked.
// After reset a clearing pass zeroes the map with busy high; after a register
// write busy is high while the registered grid geometry settles. The receiver
// cannot stall.
// ----------------------------------------------------------------------------
`include "grid_neighbor_expander_unit_assert.svh"

module grid_neighbor_expander_unit #(
	parameter int MAX_SIDE  = gne_pkg::MAX_SIDE_DEF,
	parameter int MAX_CELLS = gne_pkg::MAX_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [gne_pkg::IDX_W-1:0]     cell_index,
	input  logic                          blocked,
	input  logic                          cfg_we,
	input  logic [gne_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gne_pkg::CFG_W-1:0]     cfg_data,
	output logic                          result_valid,
	output logic [gne_pkg::IDX_W-1:0]     neighbor_index,
	output logic                          last_of_run,
	output logic                          bad_index
);

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int ROW_W  = $clog2(MAX_SIDE);
	localparam int PROD_W = 2 * SIDE_W;
	localparam int ADDR_W = $clog2(MAX_CELLS);
	localparam int CELL_W = $clog2(MAX_CELLS + 1);
	localparam int DIV_W  = SIDE_W + ROW_W - 1;
	localparam int S_END  = (ROW_W > gne_pkg::N_SLOT + 1) ? ROW_W : gne_pkg::N_SLOT + 1;
	localparam int STEP_W = $clog2(S_END + 1);

	typedef enum logic [2:0] {
		F_CLEAR = 3'b001,
		F_IDLE  = 3'b010,
		F_QUERY = 3'b100
	} gne_fstate_t;

	gne_fstate_t                   state_q;
	logic [ADDR_W-1:0]             clr_addr_q;
	logic [gne_pkg::CFG_W-1:0]     grid_width_q;
	logic [gne_pkg::CFG_W-1:0]     grid_height_q;
	logic [1:0]                    cfg_wr_q;
	logic [SIDE_W-1:0]             cap_tab [MAX_SIDE];
	logic [SIDE_W-1:0]             w_cl;
	logic [SIDE_W-1:0]             h_cl;
	logic [SIDE_W-1:0]             cap;
	logic [SIDE_W-1:0]             w_eff_q;
	logic [SIDE_W-1:0]             h_eff_q;
	logic [CELL_W-1:0]             cells_q;
	logic [gne_pkg::IDX_W-1:0]     idx_q;
	logic [gne_pkg::IDX_W-1:0]     rem_q;
	logic [DIV_W-1:0]              dvs_q;
	logic [STEP_W-1:0]             step_q;
	logic [gne_pkg::N_SLOT-1:0]    blk_q;
	logic [gne_pkg::IDX_W-1:0]     cand [gne_pkg::N_SLOT];
	logic [gne_pkg::SLOT_W-1:0]    rd_slot;
	logic                          finishing;
	logic                          emit_ready;
	logic                          load;
	logic                          accept;
	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_waddr;
	logic [0:0]                    mem_wdata;
	logic [ADDR_W-1:0]             mem_raddr;
	logic [0:0]                    rd_data;
	gne_pkg::gne_set_t             set_fin;
	logic                          open;
	logic [SIDE_W-1:0]             col;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= gne_pkg::GRID_SIZE_RST;
			grid_height_q <= gne_pkg::GRID_SIZE_RST;
			cfg_wr_q      <= '0;
		end else begin
			cfg_wr_q <= {cfg_wr_q[0], cfg_we};
			if (cfg_we) begin
				case (cfg_index)
					gne_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					gne_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Row limit for each width: the grid may not exceed MAX_CELLS cells.
	for (genvar g = 1; g <= MAX_SIDE; g++) begin : g_cap
		localparam int CAP_RAW = MAX_CELLS / g;
		localparam int CAP_LIM = (CAP_RAW > MAX_SIDE) ? MAX_SIDE : CAP_RAW;
		assign cap_tab[g-1] = SIDE_W'(CAP_LIM);
	end

	// Clamp width and height to the supported range.
	always_comb begin
		if (grid_width_q == '0) begin
			w_cl = SIDE_W'(1);
		end else if (32'(grid_width_q) > 32'(MAX_SIDE)) begin
			w_cl = SIDE_W'(MAX_SIDE);
		end else begin
			w_cl = SIDE_W'(grid_width_q);
		end
		if (grid_height_q == '0) begin
			h_cl = SIDE_W'(1);
		end else if (32'(grid_height_q) > 32'(MAX_SIDE)) begin
			h_cl = SIDE_W'(MAX_SIDE);
		end else begin
			h_cl = SIDE_W'(grid_height_q);
		end
		cap = cap_tab[ROW_W'(w_cl - SIDE_W'(1))];
	end

	// Effective geometry, registered in two levels.
	always_ff @(posedge clk) begin
		w_eff_q <= w_cl;
		h_eff_q <= (h_cl > cap) ? cap : h_cl;
		cells_q <= CELL_W'(PROD_W'(w_eff_q) * PROD_W'(h_eff_q));
	end

	// Handshake: a new item is taken when idle or as a query hands over.
	assign finishing = (state_q == F_QUERY) && (step_q == STEP_W'(S_END));
	assign load      = finishing && emit_ready;
	assign busy      = !((state_q == F_IDLE) || load) || (|cfg_wr_q);
	assign accept    = start && !busy;

	// Map writes: the clearing pass, or an accepted write item inside the grid.
	always_comb begin
		if (state_q == F_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = 1'b0;
		end else begin
			mem_we    = accept && (kind == gne_pkg::KIND_WRITE) &&
				(32'(cell_index) < 32'(cells_q));
			mem_waddr = ADDR_W'(cell_index);
			mem_wdata = blocked;
		end
	end

	// Candidate cells of the current query.
	always_comb begin
		cand[gne_pkg::SLOT_SELF]  = idx_q;
		cand[gne_pkg::SLOT_UP]    = idx_q - gne_pkg::IDX_W'(w_eff_q);
		cand[gne_pkg::SLOT_LEFT]  = idx_q - gne_pkg::IDX_W'(1);
		cand[gne_pkg::SLOT_DOWN]  = idx_q + gne_pkg::IDX_W'(w_eff_q);
		cand[gne_pkg::SLOT_RIGHT] = idx_q + gne_pkg::IDX_W'(1);
		rd_slot = (step_q < STEP_W'(gne_pkg::N_SLOT)) ? gne_pkg::SLOT_W'(step_q) :
			gne_pkg::SLOT_W'(gne_pkg::SLOT_SELF);
		mem_raddr = ADDR_W'(cand[rd_slot]);
	end

	gne_ram #(
		.WIDTH (1),
		.DEPTH (MAX_CELLS)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	// Control: clearing pass, idle and query sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_CLEAR;
			clr_addr_q <= '0;
			step_q     <= '0;
		end else begin
			case (state_q)
				F_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(MAX_CELLS - 1)) begin
						state_q <= F_IDLE;
					end
				end
				F_IDLE: begin
					if (accept && (kind == gne_pkg::KIND_QUERY)) begin
						state_q <= F_QUERY;
						step_q  <= '0;
					end
				end
				F_QUERY: begin
					if (accept) begin
						state_q <= (kind == gne_pkg::KIND_QUERY) ? F_QUERY : F_IDLE;
						step_q  <= '0;
					end else if (load) begin
						state_q <= F_IDLE;
					end else if (!finishing) begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Query datapath: remainder unit and capture of the obstacle bits.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= cell_index;
			rem_q <= cell_index;
			dvs_q <= DIV_W'(w_eff_q) << (ROW_W - 1);
		end else if (state_q == F_QUERY) begin
			if (step_q < STEP_W'(ROW_W)) begin
				if (32'(rem_q) >= 32'(dvs_q)) begin
					rem_q <= rem_q - gne_pkg::IDX_W'(dvs_q);
				end
				dvs_q <= dvs_q >> 1;
			end
			if ((step_q != '0) && (step_q <= STEP_W'(gne_pkg::N_SLOT))) begin
				blk_q[gne_pkg::SLOT_W'(step_q - STEP_W'(1))] <= rd_data[0];
			end
		end
	end

	// Build the result set once the column and all obstacle bits are known.
	always_comb begin
		col         = SIDE_W'(rem_q);
		set_fin.bad = (32'(idx_q) >= 32'(cells_q));
		open        = !set_fin.bad && !blk_q[gne_pkg::SLOT_SELF];
		for (int i = 0; i < gne_pkg::N_SLOT; i++) begin
			set_fin.idx[i] = cand[i];
		end
		set_fin.mask[gne_pkg::SLOT_SELF]  = 1'b1;
		set_fin.mask[gne_pkg::SLOT_UP]    = open && !blk_q[gne_pkg::SLOT_UP] &&
			(32'(idx_q) >= 32'(w_eff_q));
		set_fin.mask[gne_pkg::SLOT_LEFT]  = open && !blk_q[gne_pkg::SLOT_LEFT] &&
			(col != '0);
		set_fin.mask[gne_pkg::SLOT_DOWN]  = open && !blk_q[gne_pkg::SLOT_DOWN] &&
			((32'(idx_q) + 32'(w_eff_q)) < 32'(cells_q));
		set_fin.mask[gne_pkg::SLOT_RIGHT] = open && !blk_q[gne_pkg::SLOT_RIGHT] &&
			(col != (w_eff_q - SIDE_W'(1)));
	end

	gne_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (load),
		.set_in         (set_fin),
		.ready          (emit_ready),
		.result_valid   (result_valid),
		.neighbor_index (neighbor_index),
		.last_of_run    (last_of_run),
		.bad_index      (bad_index)
	);

	`GNE_ASSERT_NEXT(a_query_starts, start && !busy && (kind == gne_pkg::KIND_QUERY),
		(state_q == F_QUERY) && (step_q == '0), "accepted query did not start its sequence")
	`GNE_ASSERT_IMP(a_no_write_mid_query, (state_q == F_QUERY) && !finishing, !mem_we,
		"map written while a query is reading it")
	`GNE_ASSERT_IMP(a_clear_holds_off, state_q == F_CLEAR, busy,
		"item accepted during the clearing pass")

endmodule

>>> dv/tb_grid_neighbor_expander_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid neighbour expander testbench
// Drives obstacle writes and neighbour queries through the start/busy port
// and changes the grid geometry between phases. A scoreboard keeps its own
// obstacle map and grid size, works out the run of cells that each query
// must return, and compares every strobed result against it in order.
// ----------------------------------------------------------------------------
module tb_grid_neighbor_expander_unit;
	import gne_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int          DRAIN_PAUSE  = 16;
	localparam int          PHASE_ITEMS  = 76;
	localparam int          PHASE_COUNT  = 6;

	// One expected result of a query.
	typedef struct packed {
		logic [IDX_W-1:0] nb_idx;
		logic             last;
		logic             bad;
	} cell_result_t;

	// Scoreboard: its own obstacle map and geometry, and the queue of results
	// that accepted queries still owe.
	class expansion_ledger;
		bit               obstacle [MAX_CELLS_DEF];
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		cell_result_t     awaited [$];
		int unsigned      mismatches;

		function new();
			foreach (obstacle[i])
				obstacle[i] = 1'b0;
			width_reg  = GRID_SIZE_RST;
			height_reg = GRID_SIZE_RST;
			mismatches = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
			case (index)
				REG_GRID_WIDTH: width_reg = value;
				REG_GRID_HEIGHT: height_reg = value;
				default: ;
			endcase
		endfunction

		// Width clamped to [1, MAX_SIDE].
		function int unsigned cols();
			int unsigned w;
			w = width_reg;
			if (w < 1)
				w = 1;
			if (w > MAX_SIDE_DEF)
				w = MAX_SIDE_DEF;
			return w;
		endfunction

		// Height clamped the same way and then capped so the grid fits the map.
		function int unsigned rows();
			int unsigned h;
			int unsigned cap;
			h   = height_reg;
			cap = MAX_CELLS_DEF / cols();
			if (h < 1)
				h = 1;
			if (h > MAX_SIDE_DEF)
				h = MAX_SIDE_DEF;
			if (h > cap)
				h = cap;
			return h;
		endfunction

		function int unsigned cell_count();
			return cols() * rows();
		endfunction

		// Applies a write to the map, or queues the run of results of a query.
		function void note_item(logic k, logic [IDX_W-1:0] idx, logic blk);
			int unsigned  w;
			int unsigned  h;
			int unsigned  r;
			int unsigned  c;
			int           nr;
			int           nc;
			int unsigned  nv;
			int           row_step [4] = '{-1, 0, 1, 0};
			int           col_step [4] = '{0, -1, 0, 1};
			int unsigned  hits [$];
			cell_result_t e;
			w = cols();
			h = rows();
			if (k == KIND_WRITE) begin
				if (idx < w * h)
					obstacle[idx] = blk;
				return;
			end
			// A query outside the grid gives a single flagged result.
			if (idx >= w * h) begin
				e.nb_idx = idx;
				e.last   = 1'b1;
				e.bad    = 1'b1;
				awaited  = {awaited, e};
				return;
			end
			// The cell itself, then its free in-grid neighbours up, left, down, right.
			hits = {hits, 32'(idx)};
			if (!obstacle[idx]) begin
				r = idx / w;
				c = idx % w;
				for (int d = 0; d < 4; d++) begin
					nr = int'(r) + row_step[d];
					nc = int'(c) + col_step[d];
					if (nr < 0 || nc < 0 || nr >= int'(h) || nc >= int'(w))
						continue;
					nv = nr * w + nc;
					if (!obstacle[nv])
						hits = {hits, nv};
				end
			end
			foreach (hits[i]) begin
				e.nb_idx = IDX_W'(hits[i]);
				e.last   = (i == hits.size() - 1);
				e.bad    = 1'b0;
				awaited  = {awaited, e};
			end
		endfunction

		// Compares one strobed result with the oldest expected one.
		function void check_result(logic [IDX_W-1:0] idx, logic last, logic bad);
			cell_result_t e;
			if (awaited.size() == 0) begin
				$error("unexpected result: neighbor_index %0d last_of_run %0b bad_index %0b",
					idx, last, bad);
				mismatches++;
				return;
			end
			e = awaited.pop_front();
			if (idx !== e.nb_idx) begin
				$error("neighbor_index: expected %0d, actual %0d", e.nb_idx, idx);
				mismatches++;
			end
			if (last !== e.last) begin
				$error("last_of_run: expected %0b, actual %0b", e.last, last);
				mismatches++;
			end
			if (bad !== e.bad) begin
				$error("bad_index: expected %0b, actual %0b", e.bad, bad);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 start      = 1'b0;
	logic                 kind       = KIND_WRITE;
	logic [IDX_W-1:0]     cell_index = '0;
	logic                 blocked    = 1'b0;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_GRID_WIDTH;
	logic [CFG_W-1:0]     cfg_data   = '0;
	logic                 busy;
	logic                 result_valid;
	logic [IDX_W-1:0]     neighbor_index;
	logic                 last_of_run;
	logic                 bad_index;

	expansion_ledger sb = new();
	int unsigned     cycle_count = 0;
	int unsigned     sender_idle_pct = 23;
	int              focus_cell = 0;

	grid_neighbor_expander_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.cell_index     (cell_index),
		.blocked        (blocked),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.neighbor_index (neighbor_index),
		.last_of_run    (last_of_run),
		.bad_index      (bad_index)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Every strobed result goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(neighbor_index, last_of_run, bad_index);
	end

	// Presents one item after a random gap and holds it until it is accepted.
	task automatic send_item(logic k, logic [IDX_W-1:0] idx, logic blk);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		kind       <= k;
		cell_index <= idx;
		blocked    <= blk;
		do @(posedge clk); while (busy);
		sb.note_item(k, idx, blk);
	endtask

	// Stops sending and waits until the block has nothing left to do.
	task automatic drain();
		start <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(index, value);
		do @(posedge clk); while (busy);
	endtask

	task automatic resize_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		drain();
		write_register(REG_GRID_WIDTH, w);
		write_register(REG_GRID_HEIGHT, h);
		focus_cell = $urandom_range(0, sb.cell_count() - 1);
	endtask

	// Random item, mostly clustered around a moving focus cell so that writes
	// and queries meet, with some uniform and some full-range indices.
	task automatic pick_item(output logic k, output logic [IDX_W-1:0] idx, output logic blk);
		int cells;
		int w;
		int pos;
		int sel;
		cells = sb.cell_count();
		w     = sb.cols();
		if ($urandom_range(0, 9) == 0)
			focus_cell = $urandom_range(0, cells - 1);
		k   = ($urandom_range(0, 99) < 60) ? KIND_QUERY : KIND_WRITE;
		blk = ($urandom_range(0, 99) < 35);
		sel = $urandom_range(0, 99);
		if (sel < 65) begin
			pos = focus_cell + int'($urandom_range(0, 2 * w + 2)) - (w + 1);
			pos = ((pos % cells) + cells) % cells;
			idx = pos[IDX_W-1:0];
		end else if (sel < 85) begin
			idx = IDX_W'($urandom_range(0, cells - 1));
		end else begin
			idx = IDX_W'($urandom_range(0, MAX_CELLS_DEF - 1));
		end
	endtask

	initial begin
		logic             k;
		logic [IDX_W-1:0] idx;
		logic             blk;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;

		// Reset, then let the map clearing pass finish.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		do @(posedge clk); while (busy);

		// Full 64 by 64 grid: corners, an interior cell, blocked neighbours and
		// a blocked queried cell.
		send_item(KIND_QUERY, 12'd0, 1'b0);
		send_item(KIND_QUERY, 12'd4095, 1'b1);
		send_item(KIND_QUERY, 12'd65, 1'b0);
		send_item(KIND_WRITE, 12'd1, 1'b1);
		send_item(KIND_WRITE, 12'd64, 1'b1);
		send_item(KIND_QUERY, 12'd0, 1'b0);
		send_item(KIND_WRITE, 12'd0, 1'b1);
		send_item(KIND_QUERY, 12'd0, 1'b0);
		send_item(KIND_WRITE, 12'd0, 1'b0);
		send_item(KIND_QUERY, 12'd65, 1'b0);
		send_item(KIND_WRITE, 12'd1, 1'b0);
		send_item(KIND_WRITE, 12'd64, 1'b0);

		// Width of zero acts as one and an oversized height is clamped: one column.
		resize_grid(7'd0, 7'd127);
		send_item(KIND_QUERY, 12'd0, 1'b0);
		send_item(KIND_QUERY, 12'd63, 1'b0);
		send_item(KIND_QUERY, 12'd64, 1'b0);
		send_item(KIND_WRITE, 12'd100, 1'b1);
		send_item(KIND_QUERY, 12'd4095, 1'b0);

		// Oversized width and zero height: one row.
		resize_grid(7'd127, 7'd0);
		send_item(KIND_QUERY, 12'd0, 1'b0);
		send_item(KIND_QUERY, 12'd63, 1'b0);
		send_item(KIND_QUERY, 12'd64, 1'b0);

		// Single cell grid.
		resize_grid(7'd1, 7'd1);
		send_item(KIND_QUERY, 12'd0, 1'b0);
		send_item(KIND_WRITE, 12'd0, 1'b1);
		send_item(KIND_QUERY, 12'd0, 1'b0);
		send_item(KIND_QUERY, 12'd1, 1'b0);
		send_item(KIND_WRITE, 12'd0, 1'b0);

		// Random phases, each on its own geometry; the sender idles more in the
		// middle two phases and not at all in the last two phases.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin
					w = 7'd64;
					h = 7'd64;
				end
				1, 4: begin
					w = CFG_W'($urandom_range(2, 10));
					h = CFG_W'($urandom_range(2, 10));
				end
				2: begin
					w = CFG_W'($urandom_range(0, 127));
					h = CFG_W'($urandom_range(0, 127));
				end
				3: begin
					w = 7'd1;
					h = CFG_W'($urandom_range(2, 20));
				end
				default: begin
					w = CFG_W'($urandom_range(50, 64));
					h = CFG_W'($urandom_range(2, 4));
				end
			endcase
			sender_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 54 : 0;
			resize_grid(w, h);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick_item(k, idx, blk);
				send_item(k, idx, blk);
			end
		end

		drain();
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
